// ===== rtl/mpm_pkg.sv =====
// shared types and constants of the mandelbrot pixel membership unit
`default_nettype none

package mpm_pkg;

  // field widths
  localparam int COORD_W   = 14;  // column, row, half sizes
  localparam int STEP_W    = 28;  // pixel spacing
  localparam int ITER_W    = 8;   // iteration count and limit
  localparam int FRAC_BITS = 28;  // fraction bits of every fixed point value

  // datapath widths
  localparam int CW = 32;  // point c, Q4.28 saturated to [-8, 8)
  localparam int ZW = 31;  // iterate fed to the squaring unit, each component in [-2, 2]
  localparam int NW = 34;  // freshly computed iterate and squared terms
  localparam int PW = 2 * ZW;  // full product of two iterate components

  // escape thresholds in the iterate format
  localparam logic signed [NW-1:0] ESC_COMP_POS = NW'(64'sd2 <<< FRAC_BITS);
  localparam logic signed [NW-1:0] ESC_COMP_NEG = -ESC_COMP_POS;
  localparam logic signed [NW-1:0] ESC_SQ       = NW'(64'sd4 <<< FRAC_BITS);

  // register map: index is paddr[3:2]
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER    = 2'd3;

  // reset values
  localparam logic [COORD_W-1:0] HALF_WIDTH_RST  = COORD_W'(5000);
  localparam logic [COORD_W-1:0] HALF_HEIGHT_RST = COORD_W'(5000);
  localparam logic [STEP_W-1:0]  STEP_RST        = STEP_W'(107374);
  localparam logic [ITER_W-1:0]  MAX_ITER_RST    = ITER_W'(255);

  // configuration seen by the front and back parts
  typedef struct packed {
    logic [COORD_W-1:0] half_width;
    logic [COORD_W-1:0] half_height;
    logic [STEP_W-1:0]  step;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  // one queued point c
  typedef struct packed {
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
  } c_pair_t;

endpackage

`default_nettype wire

// ===== rtl/mpm_front.sv =====
// front part: takes a pixel, maps it to the point c and pushes it into the queue
`default_nettype none

module mpm_front
  import mpm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [COORD_W-1:0] column_i,
  input  wire logic [COORD_W-1:0] row_i,
  output logic                    push_o,
  output c_pair_t                 push_data_o,
  input  wire logic               full_i
);

  localparam int DW  = COORD_W + 1;        // signed coordinate offset
  localparam int SW  = STEP_W + 1;         // step as a signed operand
  localparam int MPW = DW + SW;            // exact product width

  logic                  valid_q, valid_d;
  logic signed [MPW-1:0] pa_q, pb_q;
  logic signed [DW-1:0]  da, db;
  logic signed [SW-1:0]  step_s;
  logic                  accept;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [MPW-1:0] v);
    logic all_same;
    all_same = (v[MPW-1:CW-1] == '0) || (v[MPW-1:CW-1] == '1);
    if (all_same) begin
      return v[CW-1:0];
    end else if (v[MPW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign da     = $signed({1'b0, column_i}) - $signed({1'b0, cfg_i.half_width});
  assign db     = $signed({1'b0, cfg_i.half_height}) - $signed({1'b0, row_i});
  assign step_s = $signed({1'b0, cfg_i.step});

  assign push_o      = valid_q && !full_i;
  assign in_stall_o  = valid_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = '{ca: sat_c(pa_q), cb: sat_c(pb_q)};

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // exact c products, saturated on the way into the queue
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pa_q <= MPW'(da) * MPW'(step_s);
      pb_q <= MPW'(db) * MPW'(step_s);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpm_queue.sv =====
// short queue of points c between the front and back parts
`default_nettype none

module mpm_queue
  import mpm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire c_pair_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output c_pair_t      pop_data_o,
  output logic         empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  c_pair_t            entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpm_iter.sv =====
// back part: escape-time iteration of one point and the result register
`default_nettype none

module mpm_iter
  import mpm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ITER_W-1:0] max_iter_i,
  input  wire logic              empty_i,
  input  wire c_pair_t           pop_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   in_set_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_HOLD
  } state_e;

  state_e                state_q;
  logic                  first_q;
  logic [ITER_W-1:0]     count_q;
  logic                  result_q;
  logic                  out_valid_q;
  logic                  in_set_q;

  logic signed [CW-1:0]  ca_q, cb_q;
  logic signed [NW-1:0]  nx_q, ny_q;
  logic signed [PW-1:0]  pxx_q, pyy_q, pxy_q;

  logic signed [ZW-1:0]  zx, zy;
  logic signed [NW-1:0]  sq_x, sq_y, sq_sum, xy2, ca_ext, cb_ext, nx_new, ny_new;
  logic                  comp_esc, sum_esc, limit_hit, out_free;

  assign zx     = nx_q[ZW-1:0];
  assign zy     = ny_q[ZW-1:0];
  assign sq_x   = $signed(pxx_q[FRAC_BITS+NW-1:FRAC_BITS]);
  assign sq_y   = $signed(pyy_q[FRAC_BITS+NW-1:FRAC_BITS]);
  // floor(2xy) is the product shifted one place less
  assign xy2    = $signed(pxy_q[FRAC_BITS+NW-2:FRAC_BITS-1]);
  assign ca_ext = {{(NW-CW){ca_q[CW-1]}}, ca_q};
  assign cb_ext = {{(NW-CW){cb_q[CW-1]}}, cb_q};
  assign sq_sum = sq_x + sq_y;
  assign nx_new = sq_x - sq_y + ca_ext;
  assign ny_new = xy2 + cb_ext;

  assign comp_esc  = (nx_q > ESC_COMP_POS) || (nx_q < ESC_COMP_NEG) ||
                     (ny_q > ESC_COMP_POS) || (ny_q < ESC_COMP_NEG);
  assign sum_esc   = sq_sum > ESC_SQ;
  assign limit_hit = count_q >= max_iter_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign in_set_o    = in_set_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      count_q     <= '0;
      result_q    <= 1'b0;
      out_valid_q <= 1'b0;
      in_set_q    <= 1'b0;
    end else begin
      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            first_q <= 1'b1;
            count_q <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // component escape or limit reached ends the point here
          if (!first_q && (comp_esc || limit_hit)) begin
            result_q <= (count_q == max_iter_i);
            state_q  <= ST_HOLD;
          end else begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (!first_q && sum_esc) begin
            result_q <= (count_q == max_iter_i);
            state_q  <= ST_HOLD;
          end else begin
            count_q <= count_q + ITER_W'(1);
            first_q <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            in_set_q <= result_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ca_q <= pop_data_i.ca;
      cb_q <= pop_data_i.cb;
      nx_q <= '0;
      ny_q <= '0;
    end
    if (state_q == ST_MUL) begin
      pxx_q <= PW'(zx) * PW'(zx);
      pyy_q <= PW'(zy) * PW'(zy);
      pxy_q <= PW'(zx) * PW'(zy);
    end
    if (state_q == ST_ADD) begin
      nx_q <= nx_new;
      ny_q <= ny_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_pixel_membership_unit.sv =====
// top level of the mandelbrot pixel membership unit: registers, front, queue, back
`default_nettype none

// escape-time membership test, one pixel per transaction on the input side and
// one in_set bit per transaction on the output side, in the same order. the
// front maps (column, row) to c = ((column - half_width) * step,
// (half_height - row) * step) in Q4.28, saturated to [-8, 8); the products are
// registered, and c drops into a small queue. the back iterates z = z*z + c:
// every iteration is a multiply state (x*x, y*y and x*y side by side, with a
// test of each component against +-2 and of the max_iter limit) and an add
// state (escape test on |z|^2, next iterate). in_set is 1 exactly when the count
// reached max_iter, even if that last iterate escaped; max_iter = 0 always
// gives 0. the queue lets a few pixels wait while the back works, and the
// output register lets the back start the next pixel while a result waits to
// be taken. registers sit at byte addresses 0 (half_width), 4 (half_height),
// 8 (step) and 12 (max_iter); the user must see that they are written only
// while the unit is idle, as nothing in the unit enforces this.

module mandelbrot_pixel_membership_unit
  import mpm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // pixel input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [COORD_W-1:0]    column_i,
  input  wire logic [COORD_W-1:0]    row_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       in_set_o
);

  cfg_t                 cfg_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  c_pair_t              push_data, pop_data;
  logic                 push, pop, full, empty;

  // register file, decoded on the word index only
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_width  <= HALF_WIDTH_RST;
      cfg_q.half_height <= HALF_HEIGHT_RST;
      cfg_q.step        <= STEP_RST;
      cfg_q.max_iter    <= MAX_ITER_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HALF_WIDTH:  cfg_q.half_width  <= pwdata[COORD_W-1:0];
        REG_HALF_HEIGHT: cfg_q.half_height <= pwdata[COORD_W-1:0];
        REG_STEP:        cfg_q.step        <= pwdata[STEP_W-1:0];
        REG_MAX_ITER:    cfg_q.max_iter    <= pwdata[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_HALF_WIDTH:  prdata = 32'(cfg_q.half_width);
      REG_HALF_HEIGHT: prdata = 32'(cfg_q.half_height);
      REG_STEP:        prdata = 32'(cfg_q.step);
      REG_MAX_ITER:    prdata = 32'(cfg_q.max_iter);
      default:         prdata = '0;
    endcase
  end

  // front: pixel to point c
  mpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // points waiting for the iteration unit
  mpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // back: escape-time loop and result register
  mpm_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_iter_i  (cfg_q.max_iter),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .in_set_o    (in_set_o)
  );

endmodule

`default_nettype wire
